// ----- hdl/sha1_stream_hasher_unit_assert.svh -----
// Assertion macros for the hasher RTL.
`ifndef SHA1_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA1_STREAM_HASHER_UNIT_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SHA1SH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define SHA1SH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/sha1sh_pkg.sv -----
package sha1sh_pkg;

   localparam int unsigned WordWidth    = 32;
   localparam int unsigned DigestWords  = 5;
   localparam int unsigned Rounds       = 80;
   localparam int unsigned BlockBytes   = 64;
   localparam int unsigned LenStartByte = 56;

   typedef logic [WordWidth-1:0]               word_type;
   typedef logic [DigestWords-1:0][WordWidth-1:0] chain_type;
   typedef logic [6:0]                          round_type;
   typedef logic [5:0]                          fill_type;
   typedef logic [60:0]                         count_type;
   typedef logic [2:0]                          widx_type;
   typedef logic [7:0]                          byte_type;

   localparam chain_type H_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                   32'hefcdab89, 32'h67452301};

   localparam word_type K_CH  = 32'h5a827999;
   localparam word_type K_PA1 = 32'h6ed9eba1;
   localparam word_type K_MAJ = 32'h8f1bbcdc;
   localparam word_type K_PA2 = 32'hca62c1d6;

   localparam byte_type PAD_MARK_BYTE = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_ADD,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic     shift_byte;
      logic     expand;
      byte_type byte_in;
   } sched_ctrl_type;

   typedef struct packed {
      logic load;
      logic step;
   } round_ctrl_type;

   function automatic word_type round_k(round_type r);
      word_type k;
      if (r < 7'd20) begin
         k = K_CH;
      end else if (r < 7'd40) begin
         k = K_PA1;
      end else if (r < 7'd60) begin
         k = K_MAJ;
      end else begin
         k = K_PA2;
      end
      return k;
   endfunction

   function automatic word_type round_f(round_type r, word_type b, word_type c,
                                        word_type d);
      word_type f;
      if (r < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (r < 7'd40) begin
         f = b ^ c ^ d;
      end else if (r < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

// ----- hdl/sha1sh_req_if.sv -----
interface sha1sh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_valid,
                   output end_of_message, input ready);
   modport sink (input valid, input data_byte, input byte_valid,
                 input end_of_message, output ready);
endinterface

// ----- hdl/sha1sh_rsp_if.sv -----
interface sha1sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

// ----- hdl/sha1sh_sched.sv -----
module sha1sh_sched (
   input  logic                       clock,
   input  sha1sh_pkg::sched_ctrl_type ctrl,
   output sha1sh_pkg::word_type       w_out
);
   import sha1sh_pkg::*;

   localparam int unsigned BlockBits = BlockBytes * 8;

   logic [BlockBits-1:0] block_ff, block_in;
   word_type             mix;
   word_type             w_new;

   always_comb begin
      mix = block_ff[BlockBits-1-32*13 -: 32] ^ block_ff[BlockBits-1-32*8 -: 32] ^
            block_ff[BlockBits-1-32*2 -: 32] ^ block_ff[BlockBits-1 -: 32];
      w_new = {mix[30:0], mix[31]};
      block_in = block_ff;
      if (ctrl.shift_byte) begin
         block_in = {block_ff[BlockBits-9:0], ctrl.byte_in};
      end else if (ctrl.expand) begin
         block_in = {block_ff[BlockBits-33:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

   assign w_out = block_ff[BlockBits-1 -: 32];
endmodule

// ----- hdl/sha1sh_round.sv -----
module sha1sh_round (
   input  logic                       clock,
   input  sha1sh_pkg::round_ctrl_type ctrl,
   input  sha1sh_pkg::round_type      round,
   input  sha1sh_pkg::word_type       w,
   input  sha1sh_pkg::chain_type      h,
   output sha1sh_pkg::chain_type      v
);
   import sha1sh_pkg::*;

   word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type a_in, b_in, c_in, d_in, e_in;
   word_type t;

   always_comb begin
      t = {a_ff[26:0], a_ff[31:27]} + round_f(round, b_ff, c_ff, d_ff) + e_ff +
          round_k(round) + w;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (ctrl.load) begin
         a_in = h[0];
         b_in = h[1];
         c_in = h[2];
         d_in = h[3];
         e_in = h[4];
      end else if (ctrl.step) begin
         a_in = t;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   assign v = {e_ff, d_ff, c_ff, b_ff, a_ff};
endmodule

// ----- hdl/sha1_stream_hasher_unit.sv -----
// SHA-1 over a byte stream. Each req beat may carry one message byte; a beat with
// end_of_message set closes the message, and five rsp beats then return the digest,
// most significant word first, after which the unit starts a fresh message. Every
// 64th byte starts the compression: one shared round unit runs one round per cycle,
// so a full block holds req off for the 80 rounds and the fold into the chaining
// value. End of message inserts the padding one byte per cycle, pausing for any
// compression that a full block starts, runs one or two more compressions and
// presents the five digest words; req is not ready until the last digest beat is
// taken.
`include "sha1_stream_hasher_unit_assert.svh"

module sha1_stream_hasher_unit (
   input logic         clock,
   input logic         reset,
   sha1sh_req_if.sink   req_chan,
   sha1sh_rsp_if.source rsp_chan
);
   import sha1sh_pkg::*;

   localparam widx_type  LastWordIdx = widx_type'(DigestWords - 1);
   localparam round_type LastRound   = round_type'(Rounds - 1);
   localparam fill_type  LastFill    = fill_type'(BlockBytes - 1);
   localparam fill_type  LenFill     = fill_type'(LenStartByte);

   state_type state_ff, state_in;
   state_type resume_ff, resume_in;
   round_type round_ff, round_in;
   fill_type  fill_ff, fill_in;
   count_type count_ff, count_in;
   chain_type h_ff, h_in;
   widx_type  widx_ff, widx_in;

   sched_ctrl_type sc;
   round_ctrl_type rc;
   word_type       w;
   chain_type      v;

   logic       put_en;
   byte_type   put_val;
   logic       go_comp;
   logic [63:0] len_bits;
   logic [5:0]  len_base;

   sha1sh_sched u_sched (
      .clock (clock),
      .ctrl  (sc),
      .w_out (w)
   );

   sha1sh_round u_round (
      .clock (clock),
      .ctrl  (rc),
      .round (round_ff),
      .w     (w),
      .h     (h_ff),
      .v     (v)
   );

   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      round_in  = round_ff;
      fill_in   = fill_ff;
      count_in  = count_ff;
      h_in      = h_ff;
      widx_in   = widx_ff;
      put_en    = 1'b0;
      put_val   = '0;
      go_comp   = 1'b0;
      sc        = '0;
      rc        = '0;
      len_bits  = {count_ff, 3'b000};
      len_base  = {~fill_ff[2:0], 3'b000};
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.byte_valid) begin
                  put_en   = 1'b1;
                  put_val  = req_chan.data_byte;
                  count_in = count_ff + 61'd1;
               end
               if (req_chan.byte_valid && fill_ff == LastFill) begin
                  go_comp   = 1'b1;
                  resume_in = req_chan.end_of_message ? ST_PAD_MARK : ST_IDLE;
               end else if (req_chan.end_of_message) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_COMPRESS: begin
            rc.step   = 1'b1;
            sc.expand = 1'b1;
            round_in  = round_ff + 7'd1;
            if (round_ff == LastRound) begin
               round_in = '0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < DigestWords; i++) begin
               h_in[i] = h_ff[i] + v[i];
            end
            state_in = resume_ff;
         end
         ST_PAD_MARK: begin
            put_en   = 1'b1;
            put_val  = PAD_MARK_BYTE;
            state_in = ST_PAD_ZERO;
            if (fill_ff == LastFill) begin
               go_comp   = 1'b1;
               resume_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (fill_ff == LenFill) begin
               state_in = ST_PAD_LEN;
            end else begin
               put_en = 1'b1;
               if (fill_ff == LastFill) begin
                  go_comp   = 1'b1;
                  resume_in = ST_PAD_ZERO;
               end
            end
         end
         ST_PAD_LEN: begin
            put_en  = 1'b1;
            put_val = len_bits[len_base +: 8];
            if (fill_ff == LastFill) begin
               go_comp   = 1'b1;
               resume_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == LastWordIdx) begin
                  widx_in  = '0;
                  h_in     = H_INIT;
                  count_in = '0;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (put_en) begin
         sc.shift_byte = 1'b1;
         sc.byte_in    = put_val;
         fill_in       = fill_ff + 6'd1;
      end
      if (go_comp) begin
         rc.load  = 1'b1;
         round_in = '0;
         state_in = ST_COMPRESS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         resume_ff <= ST_IDLE;
         round_ff  <= '0;
         fill_ff   <= '0;
         count_ff  <= '0;
         h_ff      <= H_INIT;
         widx_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         round_ff  <= round_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         h_ff      <= h_in;
         widx_ff   <= widx_in;
      end
   end

   assign rsp_chan.digest_word = h_ff[widx_ff];
   assign rsp_chan.word_index  = widx_ff;
   assign rsp_chan.last_word   = (widx_ff == LastWordIdx);

   `SHA1SH_ASSERT_IMP(a_digest_on_block_edge, clock, reset,
      rsp_chan.valid, fill_ff == '0,
      "digest shown with a partly filled block")
   `SHA1SH_ASSERT_NEXT(a_chain_restart, clock, reset,
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last_word,
      (h_ff == H_INIT) && (count_ff == '0),
      "chain not restarted after digest")
   `SHA1SH_ASSERT_IMP(a_add_after_rounds, clock, reset,
      state_ff == ST_ADD, $past(round_ff) == LastRound,
      "fold without a full set of rounds")
   `SHA1SH_ASSERT_NEXT(a_byte_advances_fill, clock, reset,
      req_chan.valid && req_chan.ready && req_chan.byte_valid,
      fill_ff == $past(fill_ff) + 6'd1,
      "byte beat did not advance block fill")
endmodule

// ----- tb/tb_sha1_stream_hasher_unit.sv -----
`timescale 1ns / 100ps

module tb_sha1_stream_hasher_unit;
   import sha1sh_pkg::*;

   localparam int unsigned RandomItems = 305;
   localparam int unsigned SendIdleA   = 36;
   localparam int unsigned RecvIdleA   = 54;
   localparam int unsigned LongHold    = 600;
   localparam int unsigned EndDrain    = 200;
   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned DirectedCnt = 15;

   localparam int unsigned BoundaryLens [8] = '{55, 56, 57, 63, 64, 65, 119, 128};

   typedef logic [0:DigestWords-1][WordWidth-1:0] digest_words_type;

   typedef struct packed {
      byte_type         data;
      logic             has_byte;
      logic             eom;
      logic             typed;
      digest_words_type digest;
   } stim_row_type;

   typedef struct packed {
      word_type word;
      widx_type word_idx;
      logic     last;
   } digest_beat_type;

   localparam digest_words_type EmptyDigest = {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
                                               32'h95601890, 32'hafd80709};
   localparam digest_words_type AbcDigest   = {32'ha9993e36, 32'h4706816a, 32'hba3e2571,
                                               32'h7850c26c, 32'h9cd0d89d};

   localparam stim_row_type DirectedRows [DirectedCnt] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},
      '{8'h61, 1'b1, 1'b0, 1'b0, '0},
      '{8'h62, 1'b1, 1'b0, 1'b0, '0},
      '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},
      '{8'hff, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{8'hff, 1'b1, 1'b0, 1'b0, '0},
      '{8'h5a, 1'b0, 1'b0, 1'b0, '0},
      '{8'ha5, 1'b1, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{8'hff, 1'b1, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, 1'b0, '0},
      '{8'hff, 1'b0, 1'b1, 1'b1, EmptyDigest},
      '{8'h80, 1'b1, 1'b0, 1'b0, '0},
      '{8'h7f, 1'b1, 1'b1, 1'b0, '0}
   };

   logic clock;
   logic reset;

   sha1sh_req_if req_chan ();
   sha1sh_rsp_if rsp_chan ();

   sha1_stream_hasher_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   word_type        hash_state [DigestWords];
   byte_type        block_buf [BlockBytes];
   fill_type        block_fill;
   count_type       msg_bytes;
   digest_beat_type expected_digest [$];

   int unsigned send_idle_pct = SendIdleA;
   int unsigned recv_idle_pct = RecvIdleA;
   logic        long_hold_req = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic word_type rol(input word_type x, input int unsigned n);
      return (x << n) | (x >> (WordWidth - n));
   endfunction

   function automatic void reset_chain();
      for (int i = 0; i < DigestWords; i++) begin
         hash_state[i] = H_INIT[i];
      end
      block_fill = '0;
      msg_bytes  = '0;
   endfunction

   function automatic void push_block_byte(input byte_type v);
      word_type sched [Rounds];
      word_type a, b, c, d, e, f, k, t;
      block_buf[block_fill] = v;
      block_fill++;
      if (block_fill != 0) return;
      for (int r = 0; r < 16; r++) begin
         sched[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
      end
      for (int r = 16; r < Rounds; r++) begin
         sched[r] = rol(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
      end
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int r = 0; r < Rounds; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_CH;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_PA1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = K_PA2;
         end
         t = rol(a, 5) + f + e + k + sched[r];
         e = d;
         d = c;
         c = rol(b, 30);
         b = a;
         a = t;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
      hash_state[4] += e;
   endfunction

   function automatic void absorb_beat(input byte_type data, input logic has_byte,
                                       input logic eom);
      logic [63:0]     bit_len;
      digest_beat_type beat;
      if (has_byte) begin
         push_block_byte(data);
         msg_bytes++;
      end
      if (!eom) return;
      bit_len = {msg_bytes, 3'b000};
      push_block_byte(PAD_MARK_BYTE);
      while (block_fill != LenStartByte) begin
         push_block_byte(8'h00);
      end
      for (int i = 0; i < 8; i++) begin
         push_block_byte(bit_len[63 - 8*i -: 8]);
      end
      for (int i = 0; i < DigestWords; i++) begin
         beat.word     = hash_state[i];
         beat.word_idx = widx_type'(i);
         beat.last     = (i == DigestWords - 1);
         expected_digest.push_back(beat);
      end
      reset_chain();
   endfunction

   // Offer one beat after a random idle gap; return once it is taken.
   task automatic send_beat(input byte_type data, input logic has_byte, input logic eom);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.data_byte      <= data;
      req_chan.byte_valid     <= has_byte;
      req_chan.end_of_message <= eom;
      do @(posedge clock); while (!req_chan.ready);
      absorb_beat(data, has_byte, eom);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      digest_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_digest.size() == 0) begin
            report_mismatch("unexpected digest word", rsp_chan.digest_word, '0);
         end else begin
            want = expected_digest.pop_front();
            if (rsp_chan.digest_word !== want.word) begin
               report_mismatch("digest_word", rsp_chan.digest_word, want.word);
            end
            if (rsp_chan.word_index !== want.word_idx) begin
               report_mismatch("word_index", 32'(rsp_chan.word_index), 32'(want.word_idx));
            end
            if (rsp_chan.last_word !== want.last) begin
               report_mismatch("last_word", 32'(rsp_chan.last_word), 32'(want.last));
            end
         end
      end
   end

   // Receiver: random back-pressure, with one long hold on request.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (LongHold) @(negedge clock);
            long_hold_req = 1'b0;
         end
         rsp_chan.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sha1_stream_hasher_unit test failed");
      $finish;
   end

   initial begin
      int unsigned      random_items;
      int unsigned      msg_len;
      logic             close_on_byte;
      digest_beat_type  beat;
      int unsigned      slot;
      random_items = 0;
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.data_byte      = '0;
      req_chan.byte_valid     = 1'b0;
      req_chan.end_of_message = 1'b0;
      reset_chain();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DirectedCnt; i++) begin
         send_beat(DirectedRows[i].data, DirectedRows[i].has_byte, DirectedRows[i].eom);
         if (DirectedRows[i].typed) begin
            for (int w = 0; w < DigestWords; w++) begin
               slot       = expected_digest.size() - DigestWords + w;
               beat       = expected_digest[slot];
               beat.word  = DirectedRows[i].digest[w];
               expected_digest[slot] = beat;
            end
         end
      end

      while (random_items < RandomItems) begin
         if (random_items >= 2 * RandomItems / 3 && send_idle_pct != 0) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            long_hold_req = 1'b1;
         end else if (random_items >= RandomItems / 3 && send_idle_pct == SendIdleA) begin
            send_idle_pct = RecvIdleA;
            recv_idle_pct = SendIdleA;
         end
         if ($urandom_range(4, 0) == 0) begin
            msg_len = BoundaryLens[$urandom_range(7, 0)];
         end else begin
            msg_len = $urandom_range(24, 0);
         end
         close_on_byte = ($urandom_range(3, 0) != 0) && (msg_len != 0);
         for (int unsigned b = 0; b < msg_len; b++) begin
            // drop in an ignored beat now and then
            if ($urandom_range(9, 0) == 0) begin
               send_beat(byte_type'($urandom), 1'b0, 1'b0);
               random_items++;
            end
            send_beat(byte_type'($urandom), 1'b1, close_on_byte && (b == msg_len - 1));
         end
         if (!close_on_byte) begin
            send_beat(byte_type'($urandom), 1'b0, 1'b1);
         end
         random_items += msg_len + (close_on_byte ? 0 : 1);
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_digest.size() != 0) @(posedge clock);
      repeat (EndDrain) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sha1_stream_hasher_unit test passed");
      end else begin
         $display("sha1_stream_hasher_unit test failed");
      end
      $finish;
   end

endmodule
